// ----- sv/cdseq_pkg.sv -----
`default_nettype none
package cdseq_pkg;

	localparam int unsigned PROGRAM_COUNT          = 5;
	localparam int unsigned MAX_PROGRESSION_LENGTH = 8;

	localparam logic [31:0] LCG_MUL    = 32'd1664525;
	localparam logic [31:0] LCG_ADD    = 32'd1013904223;
	localparam logic [31:0] SEED_RESET = 32'h00C0_FFEE;

	localparam logic [2:0] PROG_LAST = 3'(PROGRAM_COUNT - 1);
	localparam logic [3:0] LEN_MAX   = 4'(MAX_PROGRESSION_LENGTH);

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_PROGRAM = 1'b0,
		CFG_SEED    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] rng;
		logic [2:0]  step;
		logic [2:0]  degree;
	} state_t;

	typedef struct packed {
		logic       markov;
		logic [2:0] prog;
	} mode_t;

	localparam logic [2:0] PROG_ROM [8][8] = '{
		'{3'd1, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd5, 3'd6, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd4, 3'd5, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd6, 3'd3, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd4, 3'd6, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
	};

	localparam logic [3:0] PROG_LEN [8] = '{
		4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd0, 4'd0, 4'd0
	};

	// floor(cumulative_weight * 2^24 / 100); u <= thr  <=>  u*100 <= cum*2^24
	// last column is always the full row total, so the seventh degree is never reached
	localparam logic [24:0] MARKOV_THR [7][6] = '{
		'{25'd1677721, 25'd2516582, 25'd3355443, 25'd8388608, 25'd12582912, 25'd16777216},
		'{25'd4194304, 25'd5033164, 25'd5872025, 25'd7549747, 25'd14260633, 25'd16777216},
		'{25'd2516582, 25'd4194304, 25'd5033164, 25'd10066329, 25'd11744051, 25'd16777216},
		'{25'd5872025, 25'd7549747, 25'd7549747, 25'd8388608, 25'd14260633, 25'd16777216},
		'{25'd8388608, 25'd9227468, 25'd9227468, 25'd10905190, 25'd11744051, 25'd16777216},
		'{25'd3355443, 25'd6710886, 25'd7549747, 25'd12582912, 25'd15938355, 25'd16777216},
		'{25'd8388608, 25'd10066329, 25'd10066329, 25'd13421772, 25'd16777216, 25'd16777216}
	};

endpackage
`default_nettype wire

// ----- sv/cdseq_if.sv -----
`default_nettype none
interface cdseq_req_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink   (input valid, input advance, output ready);
endinterface

interface cdseq_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] degree;
	logic [2:0] step_index;

	modport source (output valid, output degree, output step_index, input ready);
	modport sink   (input valid, input degree, input step_index, output ready);
endinterface
`default_nettype wire

// ----- sv/cdseq_step.sv -----
`default_nettype none
module cdseq_step (
	input  var cdseq_pkg::state_t cur,
	input  var cdseq_pkg::mode_t  mode,
	input  wire logic             advance,
	output     cdseq_pkg::state_t nxt
);
	import cdseq_pkg::*;

	logic [31:0] rng_next;
	logic [23:0] u;
	logic [2:0]  row;
	logic [2:0]  pick;
	logic [3:0]  len;
	logic [3:0]  step_inc;
	logic [2:0]  rom_d;

	assign rng_next = cur.rng * LCG_MUL + LCG_ADD;
	assign u        = rng_next[31:8];

	always_comb begin
		if (cur.degree == 3'd0) begin
			row = 3'd0;
		end else begin
			row = cur.degree - 3'd1;
		end
	end

	// lowest threshold met wins
	always_comb begin
		if (cur.degree == 3'd0) begin
			pick = 3'd1;
		end else if (cur.degree == 3'd7) begin
			pick = 3'd6;
		end else begin
			pick = cur.degree;
		end
		for (int i = 5; i >= 0; i--) begin
			if ({1'b0, u} <= MARKOV_THR[row][i]) begin
				pick = 3'(i + 1);
			end
		end
	end

	always_comb begin
		if (PROG_LEN[mode.prog] > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = PROG_LEN[mode.prog];
		end
	end

	assign step_inc = {1'b0, cur.step} + 4'd1;
	assign rom_d    = PROG_ROM[mode.prog][cur.step];

	always_comb begin
		nxt = cur;
		if (advance) begin
			if (mode.markov) begin
				nxt.rng    = rng_next;
				nxt.degree = pick;
			end else if (len == 4'd0) begin
				nxt.degree = 3'd1;
				nxt.step   = 3'd0;
			end else begin
				nxt.step   = (step_inc == len) ? 3'd0 : step_inc[2:0];
				nxt.degree = (rom_d == 3'd0) ? 3'd1 : rom_d;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/chord_degree_sequencer_unit.sv -----
`default_nettype none
// Chord degree sequencer: one result item (degree, step_index) per request item,
// one item per cycle sustained while results are taken. Each request passes
// through an input register, then next-state logic into the result and state
// registers, before its result item is presented. The
// Markov path is a 32x21 LCG multiply-add feeding six threshold compares; the
// fixed path is a ROM lookup. Writing program_select restarts the progression
// at step 0, degree 1; writing seed_value loads the generator (zero loads 1).
// Write configuration only while no item is in flight.
module chord_degree_sequencer_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	cdseq_req_if.sink         req,
	cdseq_rsp_if.source       rsp,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import cdseq_pkg::*;

	state_t state_q;
	state_t state_nxt;
	mode_t  mode_q;

	logic       v_s1;
	logic       adv_s1;
	logic       rsp_v_q;
	logic [2:0] degree_q;
	logic [2:0] step_q;
	logic       move;

	assign move      = v_s1 && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1 || move;

	assign rsp.valid      = rsp_v_q;
	assign rsp.degree     = degree_q;
	assign rsp.step_index = step_q;

	cdseq_step u_step (
		.cur     (state_q),
		.mode    (mode_q),
		.advance (adv_s1),
		.nxt     (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			adv_s1 <= req.advance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (move) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			degree_q <= state_nxt.degree;
			step_q   <= state_nxt.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rng    <= SEED_RESET;
			state_q.step   <= 3'd0;
			state_q.degree <= 3'd1;
			mode_q.markov  <= 1'b0;
			mode_q.prog    <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PROGRAM: begin
					state_q.step   <= 3'd0;
					state_q.degree <= 3'd1;
					if (cfg_data[3]) begin
						mode_q.markov <= 1'b1;
						mode_q.prog   <= 3'd0;
					end else begin
						mode_q.markov <= 1'b0;
						mode_q.prog   <= ({1'b0, cfg_data[2:0]} > {1'b0, PROG_LAST}) ?
							PROG_LAST : cfg_data[2:0];
					end
				end
				CFG_SEED: begin
					state_q.rng <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
				end
				default: begin
				end
			endcase
		end else if (move) begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- test/chord_degree_sequencer_unit_test.sv -----
`timescale 1ns / 100ps
module chord_degree_sequencer_unit_test;
	import cdseq_pkg::*;

	localparam logic [6:0] TRANSITION_WEIGHT [7][7] = '{
		'{7'd10, 7'd5,  7'd5, 7'd30, 7'd25, 7'd25, 7'd0},
		'{7'd25, 7'd5,  7'd5, 7'd10, 7'd40, 7'd15, 7'd0},
		'{7'd15, 7'd10, 7'd5, 7'd30, 7'd10, 7'd30, 7'd0},
		'{7'd35, 7'd10, 7'd0, 7'd5,  7'd35, 7'd15, 7'd0},
		'{7'd50, 7'd5,  7'd0, 7'd10, 7'd5,  7'd30, 7'd0},
		'{7'd20, 7'd20, 7'd5, 7'd30, 7'd20, 7'd5,  7'd0},
		'{7'd50, 7'd10, 7'd0, 7'd20, 7'd20, 7'd0,  7'd0}
	};
	localparam logic [2:0] CHORD_ROM [5][4] = '{
		'{3'd1, 3'd4, 3'd0, 3'd0},
		'{3'd1, 3'd5, 3'd6, 3'd4},
		'{3'd1, 3'd4, 3'd5, 3'd1},
		'{3'd1, 3'd6, 3'd3, 3'd7},
		'{3'd1, 3'd4, 3'd6, 3'd5}
	};
	localparam int CHORD_LEN [5] = '{2, 4, 4, 4, 4};

	typedef struct packed {
		logic [2:0] degree;
		logic [2:0] step;
	} chord_t;

	class chord_tracker;
		logic [31:0] rng;
		logic [2:0]  step;
		logic [2:0]  degree;
		logic        markov;
		logic [2:0]  prog;
		chord_t      pending_chords[$];
		int          failures;

		function new();
			rng      = SEED_RESET;
			step     = 3'd0;
			degree   = 3'd1;
			markov   = 1'b0;
			prog     = 3'd0;
			failures = 0;
		endfunction

		function void write_register(cfg_idx_t idx, logic [31:0] data);
			if (idx == CFG_PROGRAM) begin
				if (data[3]) begin
					markov = 1'b1;
					prog   = 3'd0;
				end else begin
					markov = 1'b0;
					prog   = (data[2:0] > PROG_LAST) ? PROG_LAST : data[2:0];
				end
				step   = 3'd0;
				degree = 3'd1;
			end else begin
				rng = (data == 32'd0) ? 32'd1 : data;
			end
		endfunction

		function logic [2:0] draw_weighted_degree(logic [2:0] cur);
			int          row;
			logic [63:0] scaled;
			logic [63:0] cum;
			logic [2:0]  picked;
			bit          found;
			row    = (cur == 3'd0) ? 0 : int'(cur) - 1;
			rng    = rng * LCG_MUL + LCG_ADD;
			scaled = 64'(rng >> 8) * 64'd100;
			cum    = 64'd0;
			found  = 1'b0;
			picked = (cur == 3'd0) ? 3'd1 : ((cur > 3'd6) ? 3'd6 : cur);
			for (int i = 0; i < 7; i++) begin
				cum += 64'(TRANSITION_WEIGHT[row][i]);
				if (!found && scaled <= (cum << 24)) begin
					found  = 1'b1;
					picked = (i + 1 > 6) ? 3'd6 : 3'(i + 1);
				end
			end
			return picked;
		endfunction

		function void note_request(logic adv);
			int len;
			int pos;
			if (adv) begin
				if (markov) begin
					degree = draw_weighted_degree(degree);
				end else begin
					len    = CHORD_LEN[prog];
					pos    = int'(step) % len;
					degree = CHORD_ROM[prog][pos];
					step   = 3'((pos + 1) % len);
				end
			end
			pending_chords.push_back('{degree: degree, step: step});
		endfunction

		function void check_response(logic [2:0] deg, logic [2:0] stp);
			chord_t want;
			if (pending_chords.size() == 0) begin
				$error("unexpected result item: degree %0d, step_index %0d", deg, stp);
				failures++;
				return;
			end
			want = pending_chords.pop_front();
			if (deg !== want.degree) begin
				$error("degree: expected %0d, actual %0d", want.degree, deg);
				failures++;
			end
			if (stp !== want.step) begin
				$error("step_index: expected %0d, actual %0d", want.step, stp);
				failures++;
			end
		endfunction

		function int pending();
			return pending_chords.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	bit          req_burst;
	bit          rsp_burst;
	chord_tracker tracker;

	cdseq_req_if req_ch();
	cdseq_rsp_if rsp_ch();

	chord_degree_sequencer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// a wait with cfg_we low after each write keeps back-to-back writes apart
	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.write_register(idx, data);
		@(posedge clk);
	endtask

	task automatic write_program(logic [3:0] nib);
		logic [31:0] data;
		data      = $urandom();
		data[3:0] = nib;
		write_reg(CFG_PROGRAM, data);
	endtask

	task automatic send_items(int count, int adv_pct);
		int   gap;
		logic adv;
		for (int i = 0; i < count; i++) begin
			gap = req_burst ? 0 : $urandom_range(0, 15);
			adv = ($urandom_range(0, 99) < adv_pct);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_ch.valid   <= 1'b1;
			req_ch.advance <= adv;
			do @(posedge clk); while (!req_ch.ready);
			tracker.note_request(adv);
		end
		req_ch.valid <= 1'b0;
	endtask

	// all results back, then a wait so the pipeline is empty
	task automatic drain();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always begin : result_sink
		int gap;
		gap = rsp_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			rsp_ch.ready <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rsp_ch.ready <= 1'b1;
		do @(posedge clk); while (!rsp_ch.valid);
		tracker.check_response(rsp_ch.degree, rsp_ch.step_index);
	end

	initial begin
		#5_000_000;
		$display("chord_degree_sequencer_unit_test NOT OK");
		$finish;
	end

	initial begin
		int          sent;
		int          count;
		int          pct;
		logic [31:0] seed;
		tracker        = new();
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_PROGRAM;
		cfg_data       = 32'd0;
		req_ch.valid   = 1'b0;
		req_ch.advance = 1'b0;
		rsp_ch.ready   = 1'b0;
		req_burst      = 1'b0;
		rsp_burst      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, then wrap of the two-chord progression
		send_items(1, 0);
		send_items(3, 100);
		drain();
		// progression holding degree seven
		write_program(4'd3);
		send_items(4, 100);
		drain();
		// oversized program saturates
		write_program(4'd7);
		send_items(2, 100);
		drain();
		// Markov mode, zero seed
		write_program(4'hF);
		write_reg(CFG_SEED, 32'd0);
		send_items(4, 100);
		drain();
		// Markov mode (program value 8), all-ones seed
		write_program(4'h8);
		write_reg(CFG_SEED, 32'hFFFF_FFFF);
		send_items(3, 100);
		send_items(1, 0);
		drain();

		sent = 0;
		while (sent < 1950) begin
			if ($urandom_range(0, 3) != 0)
				write_program(4'($urandom_range(0, 15)));
			case ($urandom_range(0, 7))
				0: write_reg(CFG_SEED, 32'd0);
				1: write_reg(CFG_SEED, 32'hFFFF_FFFF);
				2, 3, 4: begin
					seed = $urandom();
					write_reg(CFG_SEED, seed);
				end
				default: ;
			endcase
			req_burst = ($urandom_range(0, 3) == 0);
			rsp_burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: pct = 100;
				1: pct = 80;
				default: pct = 50;
			endcase
			count = $urandom_range(10, 120);
			send_items(count, pct);
			sent += count;
			drain();
		end

		repeat (10) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("chord_degree_sequencer_unit_test OK");
		else
			$display("chord_degree_sequencer_unit_test NOT OK");
		$finish;
	end
endmodule
